// File: rtl/pwrt_pkg.sv
// pwrt_pkg: shared types, constants and helpers for the particle wall and
// thermostat pipeline. No dependencies; imported by pwrt_wall and the top level.
package pwrt_pkg;

   localparam int POS_FRAC_BITS_DEF = 8;

   localparam int POS_W      = 24;  // external position width
   localparam int WIDE_W     = 64;  // internal position / energy width
   localparam int DIM_W      = 15;  // box dimension registers
   localparam int MODE_W     = 2;
   localparam int TEMP_W     = 24;
   localparam int LAM_W      = 24;  // lambda, Q8.16
   localparam int LAM_FRAC   = 16;
   localparam int Q_W        = 49;  // lambda^2 quotient, one bit above the cap
   localparam int ENERGY_W   = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [LAM_W-1:0] LAM_MAX  = 24'hFFFFFF;
   // LAM_MAX^2 - 2^31: largest quotient that still gives an unsaturated lambda
   localparam logic [Q_W-1:0]   LAM_CAP  = 49'h0FFFF7E000001;
   localparam logic [Q_W-1:0]   LAM_HALF = 49'h000080000000;

   localparam logic [MODE_W-1:0] TM_ELASTIC   = 2'd0;
   localparam logic [MODE_W-1:0] TM_COMMON    = 2'd1;
   localparam logic [MODE_W-1:0] TM_SPLIT     = 2'd2;
   localparam logic [MODE_W-1:0] TM_INERT     = 2'd3;  // side walls do nothing
   localparam logic [MODE_W-1:0] CW_NONE      = 2'd0;
   localparam logic [MODE_W-1:0] CW_HOLE      = 2'd1;
   localparam logic [MODE_W-1:0] CW_DEMON     = 2'd2;
   localparam logic [MODE_W-1:0] CW_DEMON_ALT = 2'd3;  // behaves as the demon

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_HEIGHT,
      CSR_HALF_WIDTH,
      CSR_HOLE_HALF,
      CSR_CENTRAL_MODE,
      CSR_THERMO_MODE,
      CSR_TEMP_COMMON,
      CSR_TEMP_LEFT,
      CSR_TEMP_RIGHT
   } csr_index_type;

   typedef struct packed {
      logic signed [POS_W-1:0] old_x;
      logic signed [POS_W-1:0] old_y;
      logic signed [POS_W-1:0] cur_x;
      logic signed [POS_W-1:0] cur_y;
      logic                    on_right;
   } req_item_type;

   typedef struct packed {
      logic signed [POS_W-1:0] out_old_x;
      logic signed [POS_W-1:0] out_old_y;
      logic signed [POS_W-1:0] out_cur_x;
      logic signed [POS_W-1:0] out_cur_y;
      logic signed [POS_W-1:0] next_x;
      logic signed [POS_W-1:0] next_y;
      logic                    out_on_right;
      logic [ENERGY_W-1:0]     energy;
   } rsp_item_type;

   typedef struct packed {
      logic signed [WIDE_W-1:0] ox;
      logic signed [WIDE_W-1:0] oy;
      logic signed [WIDE_W-1:0] cx;
      logic signed [WIDE_W-1:0] cy;
      logic signed [WIDE_W-1:0] nx;
      logic signed [WIDE_W-1:0] ny;
      logic                     right;
   } pos_type;

   typedef struct packed {
      pos_type                  pos;
      logic                     do_mirror;
      logic                     do_therm;
      logic signed [WIDE_W-1:0] mirror_at;
      logic [TEMP_W-1:0]        temp;
   } wall_in_type;

   function automatic pos_type mirror_x(pos_type p, logic signed [WIDE_W-1:0] m);
      pos_type n;
      n    = p;
      n.nx = m - p.nx;
      n.cx = m - p.cx;
      n.ox = m - p.ox;
      return n;
   endfunction

   function automatic pos_type mirror_y(pos_type p, logic signed [WIDE_W-1:0] m);
      pos_type n;
      n    = p;
      n.ny = m - p.ny;
      n.cy = m - p.cy;
      n.oy = m - p.oy;
      return n;
   endfunction

endpackage

// File: rtl/pwrt_wall.sv
// pwrt_wall: one side wall, mirror or thermostat, as a fixed-latency pipeline.
// Pipelined restoring divider and integer square root for lambda. Uses pwrt_pkg.
module pwrt_wall
   import pwrt_pkg::*;
#(
   parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  wall_in_type in_item,
   output logic        out_valid,
   output pos_type     out_pos
);

   localparam int K_STEPS = 2 * POS_FRAC_BITS + 23;
   localparam int NDIV    = TEMP_W + K_STEPS;
   localparam int NSQ     = LAM_W;
   localparam int S_E     = 5;
   localparam int S_LAM   = S_E + 1 + NDIV + NSQ;
   localparam int NST     = S_LAM + 5;

   typedef struct packed {
      pos_type             pos;
      logic                therm;
      logic [TEMP_W-1:0]   temp;
      logic [WIDE_W-1:0]   mvx;
      logic [WIDE_W-1:0]   mvy;
      logic                nvx;
      logic                nvy;
   } car_type;

   typedef struct packed {
      logic [WIDE_W-1:0]   r;
      logic [WIDE_W-1:0]   e;
      logic [Q_W-1:0]      q;
      logic [TEMP_W-1:0]   t;
      logic                ov;
   } div_type;

   typedef struct packed {
      logic [Q_W-1:0]      a;
      logic [Q_W-1:0]      r;
      logic                ov;
   } sq_type;

   function automatic div_type div_step(div_type p);
      div_type           n;
      logic [WIDE_W-1:0] r2;
      r2  = {p.r[WIDE_W-2:0], p.t[TEMP_W-1]};
      n   = p;
      n.t = {p.t[TEMP_W-2:0], 1'b0};
      if (r2 >= p.e) begin
         n.r = r2 - p.e;
         n.q = {p.q[Q_W-2:0], 1'b1};
      end else begin
         n.r = r2;
         n.q = {p.q[Q_W-2:0], 1'b0};
      end
      n.ov = p.ov | (n.q > LAM_CAP);
      return n;
   endfunction

   function automatic sq_type sq_step(sq_type p, logic [Q_W-1:0] bitv);
      sq_type         n;
      logic [Q_W-1:0] trial;
      trial = p.r + bitv;
      n     = p;
      if (p.a >= trial) begin
         n.a = p.a - trial;
         n.r = (p.r >> 1) + bitv;
      end else begin
         n.r = p.r >> 1;
      end
      return n;
   endfunction

   car_type           car_ff [NST];
   car_type           car_in [NST];
   logic [NST-1:0]    vld_ff;

   logic [WIDE_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [WIDE_W-1:0] mdx_ff, mdy_ff, mdx_in, mdy_in;
   logic [WIDE_W-1:0] llx_ff, lhx_ff, lly_ff, lhy_ff;
   logic [WIDE_W-1:0] llx_in, lhx_in, lly_in, lhy_in;
   logic [WIDE_W-1:0] px_ff, py_ff, px_in, py_in;
   logic [WIDE_W-1:0] e_ff, e_in;
   div_type           div_ff [NDIV];
   div_type           div_in [NDIV];
   sq_type            sq_ff [NSQ];
   sq_type            sq_in [NSQ];
   logic [LAM_W-1:0]  lam_ff, lam_in;
   logic [55:0]       plx_ff, phx_ff, ply_ff, phy_ff;
   logic [55:0]       plx_in, phx_in, ply_in, phy_in;
   logic [WIDE_W-1:0] sumx, sumy;
   logic [47:0]       mx_ff, my_ff, mx_in, my_in;
   logic [WIDE_W-1:0] svx_ff, svy_ff, svx_in, svy_in;

   // carried item: mirror on entry, velocity magnitudes, final rescale
   always_comb begin
      car_in[0]       = '0;
      car_in[0].pos   = (in_item.do_mirror | in_item.do_therm) ?
                        mirror_x(in_item.pos, in_item.mirror_at) : in_item.pos;
      car_in[0].therm = in_item.do_therm;
      car_in[0].temp  = in_item.temp;
      for (int i = 1; i < NST; i++) begin
         car_in[i] = car_ff[i-1];
      end
      car_in[1].mvx = car_ff[0].pos.nx - car_ff[0].pos.cx;
      car_in[1].mvy = car_ff[0].pos.ny - car_ff[0].pos.cy;
      car_in[1].nvx = car_in[1].mvx[WIDE_W-1];
      car_in[1].nvy = car_in[1].mvy[WIDE_W-1];
      car_in[2].mvx = car_ff[1].nvx ? -car_ff[1].mvx : car_ff[1].mvx;
      car_in[2].mvy = car_ff[1].nvy ? -car_ff[1].mvy : car_ff[1].mvy;
      if (car_ff[NST-2].therm) begin
         car_in[NST-1].pos.nx = car_ff[NST-2].pos.cx + $signed(svx_ff);
         car_in[NST-1].pos.ny = car_ff[NST-2].pos.cy + $signed(svy_ff);
         car_in[NST-1].pos.ox = car_ff[NST-2].pos.cx - $signed(svx_ff);
         car_in[NST-1].pos.oy = car_ff[NST-2].pos.cy - $signed(svy_ff);
      end
   end

   // squared speed after the mirror, products cut into 32-bit halves
   always_comb begin
      dx_in  = car_ff[0].pos.cx - car_ff[0].pos.ox;
      dy_in  = car_ff[0].pos.cy - car_ff[0].pos.oy;
      mdx_in = dx_ff[WIDE_W-1] ? -dx_ff : dx_ff;
      mdy_in = dy_ff[WIDE_W-1] ? -dy_ff : dy_ff;
      llx_in = mdx_ff[31:0] * mdx_ff[31:0];
      lhx_in = mdx_ff[31:0] * mdx_ff[63:32];
      lly_in = mdy_ff[31:0] * mdy_ff[31:0];
      lhy_in = mdy_ff[31:0] * mdy_ff[63:32];
      px_in  = llx_ff + {lhx_ff[30:0], 33'd0};
      py_in  = lly_ff + {lhy_ff[30:0], 33'd0};
      e_in   = px_ff + py_ff;
   end

   // lambda^2 = 2^31 + T * 2^K / E, one quotient bit per stage
   always_comb begin
      div_type d0;
      d0.r = '0;
      d0.q = '0;
      d0.e = e_ff;
      d0.t = car_ff[S_E].temp;
      d0.ov = (e_ff == '0);
      div_in[0] = div_step(d0);
      for (int i = 1; i < NDIV; i++) begin
         div_in[i] = div_step(div_ff[i-1]);
      end
   end

   // floor square root, one result bit per stage
   always_comb begin
      sq_type s0;
      s0.a = LAM_HALF + div_ff[NDIV-1].q;
      s0.r = '0;
      s0.ov = div_ff[NDIV-1].ov;
      sq_in[0] = sq_step(s0, Q_W'(1) << (2 * (NSQ - 1)));
      for (int i = 1; i < NSQ; i++) begin
         sq_in[i] = sq_step(sq_ff[i-1], Q_W'(1) << (2 * (NSQ - 1 - i)));
      end
   end

   // velocity rescale, rounding halves away from zero
   always_comb begin
      lam_in = sq_ff[NSQ-1].ov ? LAM_MAX : sq_ff[NSQ-1].r[LAM_W-1:0];
      plx_in = car_ff[S_LAM].mvx[31:0] * lam_ff;
      phx_in = car_ff[S_LAM].mvx[63:32] * lam_ff;
      ply_in = car_ff[S_LAM].mvy[31:0] * lam_ff;
      phy_in = car_ff[S_LAM].mvy[63:32] * lam_ff;
      sumx   = {8'd0, plx_ff} + {phx_ff[31:0], 32'd0} + (WIDE_W'(1) << (LAM_FRAC - 1));
      sumy   = {8'd0, ply_ff} + {phy_ff[31:0], 32'd0} + (WIDE_W'(1) << (LAM_FRAC - 1));
      mx_in  = sumx[WIDE_W-1:LAM_FRAC];
      my_in  = sumy[WIDE_W-1:LAM_FRAC];
      svx_in = car_ff[S_LAM+2].nvx ? -{16'd0, mx_ff} : {16'd0, mx_ff};
      svy_in = car_ff[S_LAM+2].nvy ? -{16'd0, my_ff} : {16'd0, my_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NST; i++) begin
            car_ff[i] <= car_in[i];
         end
         for (int i = 0; i < NDIV; i++) begin
            div_ff[i] <= div_in[i];
         end
         for (int i = 0; i < NSQ; i++) begin
            sq_ff[i] <= sq_in[i];
         end
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         mdx_ff <= mdx_in;
         mdy_ff <= mdy_in;
         llx_ff <= llx_in;
         lhx_ff <= lhx_in;
         lly_ff <= lly_in;
         lhy_ff <= lhy_in;
         px_ff  <= px_in;
         py_ff  <= py_in;
         e_ff   <= e_in;
         lam_ff <= lam_in;
         plx_ff <= plx_in;
         phx_ff <= phx_in;
         ply_ff <= ply_in;
         phy_ff <= phy_in;
         mx_ff  <= mx_in;
         my_ff  <= my_in;
         svx_ff <= svx_in;
         svy_ff <= svy_in;
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_pos   = car_ff[NST-1].pos;

endmodule

// File: rtl/particle_wall_reflect_thermostat_unit.sv
// particle_wall_reflect_thermostat_unit: Verlet step, box walls, thermostat
// and central wall for one particle per item. Uses pwrt_pkg and pwrt_wall.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_item_type
//   rsp      out        rsp_valid/rsp_stall   rsp_item_type
//   csr      in         csr_we                csr_index, csr_wdata
//
// One item enters per cycle while req_stall is low; most of the depth lies in
// the two side-wall units, each a divider of 2*POS_FRAC_BITS+47 stages
// followed by a 24-stage square root.
// Synchronous reset clears valid bits and loads the register reset values.
// The whole pipeline holds only while the output register is full, stalled
// and the last stage holds an item; bubbles keep draining otherwise.
module particle_wall_reflect_thermostat_unit
   import pwrt_pkg::*;
#(
   parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_item,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // energy carries 2*POS_FRAC_BITS fraction bits, result wants 16
   localparam int E_SH  = 2 * POS_FRAC_BITS - 16;
   localparam int E_SHR = (E_SH > 0) ? E_SH : 0;
   localparam int E_SHL = (E_SH < 0) ? -E_SH : 0;

   function automatic logic signed [POS_W-1:0] sat24(logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi, lo;
      hi = WIDE_W'((64'sd1 <<< (POS_W - 1)) - 1);
      lo = -(64'sd1 <<< (POS_W - 1));
      if (v > hi) return hi[POS_W-1:0];
      if (v < lo) return lo[POS_W-1:0];
      return v[POS_W-1:0];
   endfunction

   // ---------------- configuration registers ----------------
   logic [DIM_W-1:0]  half_height_ff, half_width_ff, hole_half_ff;
   logic [MODE_W-1:0] central_mode_ff, thermo_mode_ff;
   logic [TEMP_W-1:0] temp_common_ff, temp_left_ff, temp_right_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_height_ff  <= DIM_W'(100);
         half_width_ff   <= DIM_W'(200);
         hole_half_ff    <= DIM_W'(10);
         central_mode_ff <= CW_NONE;
         thermo_mode_ff  <= TM_ELASTIC;
         temp_common_ff  <= TEMP_W'(256);
         temp_left_ff    <= TEMP_W'(256);
         temp_right_ff   <= TEMP_W'(256);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_HALF_HEIGHT:  half_height_ff  <= csr_wdata[DIM_W-1:0];
            CSR_HALF_WIDTH:   half_width_ff   <= csr_wdata[DIM_W-1:0];
            CSR_HOLE_HALF:    hole_half_ff    <= csr_wdata[DIM_W-1:0];
            CSR_CENTRAL_MODE: central_mode_ff <= csr_wdata[MODE_W-1:0];
            CSR_THERMO_MODE:  thermo_mode_ff  <= csr_wdata[MODE_W-1:0];
            CSR_TEMP_COMMON:  temp_common_ff  <= csr_wdata[TEMP_W-1:0];
            CSR_TEMP_LEFT:    temp_left_ff    <= csr_wdata[TEMP_W-1:0];
            CSR_TEMP_RIGHT:   temp_right_ff   <= csr_wdata[TEMP_W-1:0];
            default: ;
         endcase
      end
   end

   // wall positions in position units
   logic signed [WIDE_W-1:0] hh_q, hw_q, hole_q;
   assign hh_q   = $signed({{(WIDE_W-DIM_W){1'b0}}, half_height_ff} << POS_FRAC_BITS);
   assign hw_q   = $signed({{(WIDE_W-DIM_W){1'b0}}, half_width_ff} << POS_FRAC_BITS);
   assign hole_q = $signed({{(WIDE_W-DIM_W){1'b0}}, hole_half_ff} << POS_FRAC_BITS);

   // ---------------- flow control ----------------
   logic adv, out_load;
   logic k_vld_ff;
   logic rsp_valid_ff;
   rsp_item_type rsp_item_ff, rsp_item_in;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign adv       = out_load || !k_vld_ff;
   assign req_stall = !adv;

   // ---------------- stage A: Verlet prediction ----------------
   pos_type a_ff, a_in;
   logic    a_vld_ff;

   always_comb begin
      a_in.ox    = WIDE_W'(req_item.old_x);
      a_in.oy    = WIDE_W'(req_item.old_y);
      a_in.cx    = WIDE_W'(req_item.cur_x);
      a_in.cy    = WIDE_W'(req_item.cur_y);
      a_in.nx    = (a_in.cx <<< 1) - a_in.ox;
      a_in.ny    = (a_in.cy <<< 1) - a_in.oy;
      a_in.right = req_item.on_right;
   end

   // ---------------- stages B, C: top then bottom wall ----------------
   pos_type b_ff, b_in, c_ff, c_in;
   logic    b_vld_ff, c_vld_ff;

   always_comb begin
      b_in = (a_ff.ny > hh_q) ? mirror_y(a_ff, hh_q <<< 1) : a_ff;
      c_in = (b_ff.ny < -hh_q) ? mirror_y(b_ff, -(hh_q <<< 1)) : b_ff;
   end

   // ---------------- stage D: right wall decision ----------------
   wall_in_type d_ff, d_in, e_ff, e_in;
   logic        d_vld_ff, e_vld_ff;
   logic        r_out_vld, l_out_vld;
   pos_type     r_out_pos, l_out_pos;
   logic        hit_r, hit_l;

   always_comb begin
      hit_r          = c_ff.nx > hw_q;
      d_in.pos       = c_ff;
      d_in.mirror_at = hw_q <<< 1;
      d_in.temp      = (thermo_mode_ff == TM_COMMON) ? temp_common_ff : temp_right_ff;
      d_in.do_mirror = 1'b0;
      d_in.do_therm  = 1'b0;
      case (thermo_mode_ff) inside
         TM_ELASTIC:          d_in.do_mirror = hit_r;
         TM_COMMON, TM_SPLIT: d_in.do_therm  = hit_r;
         default: ;  // walls inactive
      endcase
   end

   pwrt_wall #(
      .POS_FRAC_BITS(POS_FRAC_BITS)
   ) u_wall_right (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (d_vld_ff),
      .in_item   (d_ff),
      .out_valid (r_out_vld),
      .out_pos   (r_out_pos)
   );

   // ---------------- stage E: left wall decision ----------------
   always_comb begin
      hit_l          = r_out_pos.nx < -hw_q;
      e_in.pos       = r_out_pos;
      e_in.mirror_at = -(hw_q <<< 1);
      e_in.temp      = (thermo_mode_ff == TM_COMMON) ? temp_common_ff : temp_left_ff;
      e_in.do_mirror = 1'b0;
      e_in.do_therm  = 1'b0;
      case (thermo_mode_ff) inside
         TM_ELASTIC:          e_in.do_mirror = hit_l;
         TM_COMMON, TM_SPLIT: e_in.do_therm  = hit_l;
         default: ;
      endcase
   end

   pwrt_wall #(
      .POS_FRAC_BITS(POS_FRAC_BITS)
   ) u_wall_left (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (e_vld_ff),
      .in_item   (e_ff),
      .out_valid (l_out_vld),
      .out_pos   (l_out_pos)
   );

   // ---------------- stage F: central wall ----------------
   pos_type f_ff, f_in;
   logic    f_vld_ff;
   logic    blocked, go_right, go_left;

   always_comb begin
      f_in     = l_out_pos;
      blocked  = (l_out_pos.ny >= hole_q) || (l_out_pos.ny <= -hole_q);
      go_right = (l_out_pos.nx > 0) && !l_out_pos.right;
      go_left  = (l_out_pos.nx < 0) && l_out_pos.right;
      if (central_mode_ff != CW_NONE) begin
         if (blocked) begin
            if (go_right || go_left) f_in = mirror_x(l_out_pos, '0);
         end else if (go_right) begin
            // hole: passable both ways, or demon lets only right-to-left through
            if (central_mode_ff == CW_HOLE) f_in.right = 1'b1;
            else                            f_in = mirror_x(l_out_pos, '0);
         end else if (go_left) begin
            f_in.right = 1'b0;
         end
      end
   end

   // ---------------- stages G..K: output energy ----------------
   pos_type           g_ff, h_ff, i_ff, j_ff, k_pos_ff;
   logic              g_vld_ff, h_vld_ff, i_vld_ff, j_vld_ff;
   logic [WIDE_W-1:0] gdx_ff, gdy_ff, hdx_ff, hdy_ff;
   logic [WIDE_W-1:0] illx_ff, ilhx_ff, illy_ff, ilhy_ff;
   logic [WIDE_W-1:0] jpx_ff, jpy_ff, ke_ff;
   logic [WIDE_W-1:0] e_shift;
   logic [ENERGY_W-1:0] energy;

   always_comb begin
      e_shift = ke_ff >> E_SHR;
      if (e_shift > (WIDE_W'(32'hFFFFFFFF) >> E_SHL)) energy = '1;
      else energy = ENERGY_W'(e_shift << E_SHL);
      rsp_item_in.out_old_x    = sat24(k_pos_ff.ox);
      rsp_item_in.out_old_y    = sat24(k_pos_ff.oy);
      rsp_item_in.out_cur_x    = sat24(k_pos_ff.cx);
      rsp_item_in.out_cur_y    = sat24(k_pos_ff.cy);
      rsp_item_in.next_x       = sat24(k_pos_ff.nx);
      rsp_item_in.next_y       = sat24(k_pos_ff.ny);
      rsp_item_in.out_on_right = k_pos_ff.right;
      rsp_item_in.energy       = energy;
   end

   // ---------------- pipeline registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
         g_vld_ff <= 1'b0;
         h_vld_ff <= 1'b0;
         i_vld_ff <= 1'b0;
         j_vld_ff <= 1'b0;
         k_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
         e_vld_ff <= r_out_vld;
         f_vld_ff <= l_out_vld;
         g_vld_ff <= f_vld_ff;
         h_vld_ff <= g_vld_ff;
         i_vld_ff <= h_vld_ff;
         j_vld_ff <= i_vld_ff;
         k_vld_ff <= j_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff     <= a_in;
         b_ff     <= b_in;
         c_ff     <= c_in;
         d_ff     <= d_in;
         e_ff     <= e_in;
         f_ff     <= f_in;
         g_ff     <= f_ff;
         gdx_ff   <= f_ff.cx - f_ff.ox;
         gdy_ff   <= f_ff.cy - f_ff.oy;
         h_ff     <= g_ff;
         hdx_ff   <= gdx_ff[WIDE_W-1] ? -gdx_ff : gdx_ff;
         hdy_ff   <= gdy_ff[WIDE_W-1] ? -gdy_ff : gdy_ff;
         i_ff     <= h_ff;
         illx_ff  <= hdx_ff[31:0] * hdx_ff[31:0];
         ilhx_ff  <= hdx_ff[31:0] * hdx_ff[63:32];
         illy_ff  <= hdy_ff[31:0] * hdy_ff[31:0];
         ilhy_ff  <= hdy_ff[31:0] * hdy_ff[63:32];
         j_ff     <= i_ff;
         jpx_ff   <= illx_ff + {ilhx_ff[30:0], 33'd0};
         jpy_ff   <= illy_ff + {ilhy_ff[30:0], 33'd0};
         k_pos_ff <= j_ff;
         ke_ff    <= jpx_ff + jpy_ff;
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= k_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   // input is held back only by a full, stalled output register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked output");

   // a frozen pipeline keeps its last-stage item
   a_freeze_hold: assert property (@(posedge clock) disable iff (reset)
      (k_vld_ff && rsp_valid_ff && rsp_stall) |=> (k_vld_ff && $stable(ke_ff)))
      else $error("last stage item changed while frozen");

   // an empty last stage never blocks the input
   a_bubble_drain: assert property (@(posedge clock) disable iff (reset)
      !k_vld_ff |-> !req_stall)
      else $error("input stalled with an empty last stage");
`endif

endmodule
